// File: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types, constants and byte classification helpers of the utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ContW  = 6;

  // lead byte masks and patterns
  localparam logic [ByteW-1:0] AsciiMask  = 8'b1000_0000;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead2Pat   = 8'b1100_0000;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead3Pat   = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'b1111_1000;
  localparam logic [ByteW-1:0] Lead4Pat   = 8'b1111_0000;
  localparam logic [ByteW-1:0] Pay2Mask   = 8'b0001_1111;
  localparam logic [ByteW-1:0] Pay3Mask   = 8'b0000_1111;
  localparam logic [ByteW-1:0] Pay4Mask   = 8'b0000_0111;
  localparam logic [ByteW-1:0] ContMask   = 8'b0011_1111;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  typedef enum logic [StatW-1:0] {
    StSuccess    = 2'd0,
    StIncomplete = 2'd1,
    StInvalid    = 2'd2
  } status_e;

  // decoder sequence state
  typedef struct packed {
    logic [LenW-1:0] exp_len;
    logic [LenW-1:0] seen;
    logic [CpW-1:0]  partial;
  } seq_state_t;

  // sequence length of a lead byte, zero if not a lead byte
  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    len = LenNone;
    if ((b & Lead2Mask) == Lead2Pat) begin
      len = LenTwo;
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      len = LenThree;
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      len = LenFour;
    end
    return len;
  endfunction

  // payload bits carried by a lead byte
  function automatic logic [CpW-1:0] lead_payload(input logic [LenW-1:0] len,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW-1:0] p;
    if (len == LenTwo) begin
      p = b & Pay2Mask;
    end else if (len == LenThree) begin
      p = b & Pay3Mask;
    end else begin
      p = b & Pay4Mask;
    end
    return {{(CpW-ByteW){1'b0}}, p};
  endfunction

endpackage

// File: hdl/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// byte-serial utf-8 decoder with one status and code point per byte
// ----------------------------------------------------------------------------
// Each input beat carries one byte of a utf-8 stream and yields exactly one
// output beat: success with a code point, incomplete, or invalid. A byte is
// captured in an input register, decoded by a shallow bit-test and six-bit
// shift step, and its result lands in an output register; the sequence state
// is updated in the same cycle the result is loaded. Throughput is one byte
// per clock, each byte passing the input and then the output register; the
// pipeline only holds when the output register is full and stalled. Overlong
// forms and surrogates are not checked, and the code point is zero unless the
// status is success.
module utf8_stream_decoder_top
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic [CpW-1:0]   code_point_o
);

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;

  // sequence state, updated when a byte moves into the output register
  seq_state_t seq_q, seq_d;

  // output register
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [CpW-1:0]   cp_q, cp_d;

  logic out_load;   // output register free to take a new result
  logic advance;    // input register hands its byte to the decode step
  logic in_take;    // input beat accepted

  // output register can load when empty or being drained this cycle
  assign out_load   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_load;
  // input register takes a byte when empty or emptying
  assign in_stall_o = in_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  utf8d_decode u_decode (
    .state_i      (seq_q),
    .byte_i       (byte_q),
    .state_o      (seq_d),
    .status_o     (status_d),
    .code_point_o (cp_d)
  );

  // control and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        seq_q <= seq_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_byte_i;
    end
    if (advance) begin
      status_q <= status_d;
      cp_q     <= cp_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign code_point_o = cp_q;

`ifndef SYNTH
  // status code 3 never leaves the block
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == StSuccess || status_q == StIncomplete ||
                     status_q == StInvalid))
    else $error("illegal status code on result beat");

  // code point is zero unless the result is a success
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != StSuccess) |-> (cp_q == '0))
    else $error("nonzero code point on non-success beat");

  // an open sequence always has a legal length
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q.exp_len == LenNone || seq_q.exp_len == LenTwo ||
     seq_q.exp_len == LenThree || seq_q.exp_len == LenFour))
    else $error("illegal expected sequence length");

  // a byte waiting behind a stalled result is not lost
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> in_valid_q)
    else $error("buffered byte dropped while output stalled");
`endif

endmodule

// File: hdl/utf8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_decode
// per-byte decode step: next sequence state and result of one byte
// ----------------------------------------------------------------------------
module utf8d_decode
  import utf8d_pkg::*;
(
  input  seq_state_t       state_i,
  input  logic [ByteW-1:0] byte_i,
  output seq_state_t       state_o,
  output status_e          status_o,
  output logic [CpW-1:0]   code_point_o
);

  logic [LenW-1:0] len;
  logic [LenW-1:0] seen_inc;
  logic [CpW-1:0]  shifted;
  logic [ByteW-1:0] cont_bits;

  assign len       = lead_length(byte_i);
  assign seen_inc  = state_i.seen + 3'd1;
  assign cont_bits = byte_i & ContMask;
  assign shifted   = {state_i.partial[CpW-ContW-1:0], cont_bits[ContW-1:0]};

  always_comb begin
    state_o      = state_i;
    status_o     = StInvalid;
    code_point_o = '0;
    if (state_i.exp_len == LenNone) begin
      state_o.seen = 3'd1;
      if ((byte_i & AsciiMask) == '0) begin
        status_o     = StSuccess;
        code_point_o = {{(CpW-ByteW){1'b0}}, byte_i};
      end else if (len != LenNone) begin
        state_o.exp_len = len;
        state_o.partial = lead_payload(len, byte_i);
        status_o        = StIncomplete;
      end
    end else if (len != LenNone) begin
      // new lead abandons the open sequence
      state_o.seen    = 3'd1;
      state_o.exp_len = len;
      state_o.partial = lead_payload(len, byte_i);
      status_o        = StInvalid;
    end else begin
      state_o.partial = shifted;
      state_o.seen    = seen_inc;
      if (seen_inc < state_i.exp_len) begin
        status_o = StIncomplete;
      end else begin
        state_o.exp_len = LenNone;
        status_o        = StSuccess;
        code_point_o    = shifted;
      end
    end
  end

endmodule
